>>> hdl/fau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fau_pkg
// Shared types, constants and the difference program for the feature unit.
// ---------------------------------------------------------------------------
package fau_pkg;

  localparam int NUM_POINTS = 68;
  localparam int ADDR_W     = 7;
  localparam int PT_W       = 12;
  localparam int NUM_FEAT   = 11;
  localparam int INDEX_W    = 4;
  localparam int VALUE_W    = 24;
  localparam int NUM_STEPS  = 35;
  localparam int STEP_W     = 6;

  // divisor multiplier of a feature: plain, two-point mean, ten-point mean
  typedef enum logic [1:0] {K_ONE, K_TWO, K_TEN} kcode_t;

  typedef struct packed {
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    logic              use_x;
    logic              grp_end;
    logic              is_scale;
    kcode_t            k;
  } step_t;

  typedef struct packed {
    logic               ovf;
    logic [VALUE_W-1:0] quo;
  } div_res_t;

  function automatic step_t mk(input int a, input int b, input logic x,
                               input logic e, input logic s, input kcode_t k);
    step_t r;
    r.a        = ADDR_W'(a);
    r.b        = ADDR_W'(b);
    r.use_x    = x;
    r.grp_end  = e;
    r.is_scale = s;
    r.k        = k;
    return r;
  endfunction

  // One landmark pair per step; a group closes with grp_end.
  function automatic step_t step_rom(input logic [STEP_W-1:0] idx);
    step_t r;
    unique case (idx)
      6'd0:  r = mk(0, 16, 1'b1, 1'b0, 1'b1, K_ONE);
      6'd1:  r = mk(1, 15, 1'b1, 1'b0, 1'b1, K_ONE);
      6'd2:  r = mk(2, 14, 1'b1, 1'b1, 1'b1, K_ONE);
      6'd3:  r = mk(21, 27, 1'b0, 1'b0, 1'b0, K_TWO);
      6'd4:  r = mk(22, 27, 1'b0, 1'b1, 1'b0, K_TWO);
      6'd5:  r = mk(17, 27, 1'b0, 1'b0, 1'b0, K_TWO);
      6'd6:  r = mk(26, 27, 1'b0, 1'b1, 1'b0, K_TWO);
      6'd7:  r = mk(17, 27, 1'b0, 1'b0, 1'b0, K_TEN);
      6'd8:  r = mk(18, 27, 1'b0, 1'b0, 1'b0, K_TEN);
      6'd9:  r = mk(19, 27, 1'b0, 1'b0, 1'b0, K_TEN);
      6'd10: r = mk(20, 27, 1'b0, 1'b0, 1'b0, K_TEN);
      6'd11: r = mk(21, 27, 1'b0, 1'b0, 1'b0, K_TEN);
      6'd12: r = mk(22, 27, 1'b0, 1'b0, 1'b0, K_TEN);
      6'd13: r = mk(23, 27, 1'b0, 1'b0, 1'b0, K_TEN);
      6'd14: r = mk(24, 27, 1'b0, 1'b0, 1'b0, K_TEN);
      6'd15: r = mk(25, 27, 1'b0, 1'b0, 1'b0, K_TEN);
      6'd16: r = mk(26, 27, 1'b0, 1'b1, 1'b0, K_TEN);
      6'd17: r = mk(37, 27, 1'b0, 1'b0, 1'b0, K_TWO);
      6'd18: r = mk(44, 27, 1'b0, 1'b1, 1'b0, K_TWO);
      6'd19: r = mk(37, 41, 1'b0, 1'b0, 1'b0, K_TWO);
      6'd20: r = mk(38, 40, 1'b0, 1'b0, 1'b0, K_TWO);
      6'd21: r = mk(43, 47, 1'b0, 1'b0, 1'b0, K_TWO);
      6'd22: r = mk(44, 46, 1'b0, 1'b1, 1'b0, K_TWO);
      6'd23: r = mk(29, 27, 1'b0, 1'b0, 1'b0, K_ONE);
      6'd24: r = mk(30, 27, 1'b0, 1'b1, 1'b0, K_ONE);
      6'd25: r = mk(48, 33, 1'b0, 1'b0, 1'b0, K_TWO);
      6'd26: r = mk(54, 33, 1'b0, 1'b1, 1'b0, K_TWO);
      6'd27: r = mk(57, 33, 1'b0, 1'b1, 1'b0, K_ONE);
      6'd28: r = mk(48, 54, 1'b1, 1'b1, 1'b0, K_ONE);
      6'd29: r = mk(49, 59, 1'b0, 1'b0, 1'b0, K_ONE);
      6'd30: r = mk(50, 58, 1'b0, 1'b0, 1'b0, K_ONE);
      6'd31: r = mk(51, 57, 1'b0, 1'b0, 1'b0, K_ONE);
      6'd32: r = mk(52, 56, 1'b0, 1'b0, 1'b0, K_ONE);
      6'd33: r = mk(53, 55, 1'b0, 1'b1, 1'b0, K_ONE);
      6'd34: r = mk(8, 27, 1'b0, 1'b1, 1'b0, K_ONE);
      default: r = mk(0, 0, 1'b0, 1'b1, 1'b0, K_ONE);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/fau_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fau_ram
// Generic single write port RAM with one registered read port.
// ---------------------------------------------------------------------------
module fau_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 68
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/fau_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fau_div
// Restoring divider, one quotient bit per cycle; keeps the low VALUE_W
// quotient bits and flags any higher bit as overflow.
// ---------------------------------------------------------------------------
module fau_div import fau_pkg::*; #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 18
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output div_res_t              res
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [NUM_W-1:0]   nsh;
  logic [DEN_W-1:0]   dreg;
  logic [DEN_W-1:0]   rem;
  logic [DEN_W:0]     trial;
  logic               qb;
  logic [DEN_W-1:0]   rem_next;

  // one long-division step
  always_comb begin
    trial    = {rem, nsh[NUM_W-1]};
    qb       = (trial >= {1'b0, dreg});
    rem_next = qb ? DEN_W'(trial - {1'b0, dreg}) : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= CNT_W'(NUM_W);
        nsh     <= num;
        dreg    <= den;
        rem     <= '0;
        res.quo <= '0;
        res.ovf <= 1'b0;
      end else if (busy) begin
        nsh     <= nsh << 1;
        rem     <= rem_next;
        res.quo <= {res.quo[VALUE_W-2:0], qb};
        res.ovf <= res.ovf | res.quo[VALUE_W-1];
        cnt     <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/facial_action_unit_features.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// facial_action_unit_features
// Stores 68 landmarks of a face and emits eleven action-unit ratios.
//
//   channel  direction  handshake                 payload
//   points   in         in_valid / in_stall       point_x, point_y, end_of_set
//   features out        out_valid / out_stall     feature_index, feature_value,
//                                                 saturated, short_set,
//                                                 last_result
//
// At end of set the sequencer walks 35 landmark pairs, each read from the
// landmark RAMs in S_RD and summed in S_ACC, and runs each of the eleven
// features through the bit-serial divider in S_DIV, then offers the result
// from S_OUT; when the scale is zero the divide is skipped and the feature
// saturates. Points are refused during that walk.
// Reset (rst, synchronous) clears the point count; the landmark RAMs
// are not cleared. An output stall holds the result, pauses the sequencer
// at its next result and refuses points while idle.
// ---------------------------------------------------------------------------
module facial_action_unit_features import fau_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [PT_W-1:0]     point_x,
  input  wire logic [PT_W-1:0]     point_y,
  input  wire logic                end_of_set,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [INDEX_W-1:0]       feature_index,
  output logic [VALUE_W-1:0]       feature_value,
  output logic                     saturated,
  output logic                     short_set,
  output logic                     last_result
);

  localparam int C     = COORD_BITS;
  localparam int ACC_W = C + 4;
  localparam int S_W   = C + 2;
  localparam int DEN_W = C + 6;
  localparam int NUM_W = C + 6 + FRAC_BITS;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_ACC, S_DIV, S_OUT} state_t;

  state_t              state;
  logic [ADDR_W-1:0]   count;
  logic [STEP_W-1:0]   step;
  logic [INDEX_W-1:0]  feat;
  logic [ACC_W-1:0]    acc;
  logic [S_W-1:0]      scale;
  logic [VALUE_W-1:0]  res_val;
  logic                res_sat;

  logic                in_acc;
  logic                wr_en;
  logic                set_full;
  logic [C-1:0]        px;
  logic [C-1:0]        py;
  step_t               st;
  logic [2*C-1:0]      rd_a;
  logic [2*C-1:0]      rd_b;
  logic [C-1:0]        va;
  logic [C-1:0]        vb;
  logic [C-1:0]        diff;
  logic [ACC_W-1:0]    acc_sum;
  logic [DEN_W-1:0]    s_ext;
  logic [DEN_W-1:0]    den;
  logic [DEN_W-1:0]    n3;
  logic [NUM_W-1:0]    num;
  logic                div_start;
  logic                div_done;
  div_res_t            div_res;
  logic                out_free;
  logic                out_load;

  assign px       = C'(point_x);
  assign py       = C'(point_y);
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign wr_en    = in_acc && (count < ADDR_W'(NUM_POINTS));
  assign set_full = (count >= ADDR_W'(NUM_POINTS - 1));
  assign out_free = !out_valid || !out_stall;
  assign st       = step_rom(step);

  // a new result is loaded for a short set or a finished feature
  assign out_load = ((state == S_IDLE) && in_acc && end_of_set && !set_full) ||
                    ((state == S_OUT) && out_free);

  // landmark store, duplicated for two reads a cycle
  fau_ram #(.WIDTH(2*C), .DEPTH(NUM_POINTS)) u_ram_a (
    .clk, .we(wr_en), .waddr(count), .wdata({px, py}), .raddr(st.a), .rdata(rd_a)
  );
  fau_ram #(.WIDTH(2*C), .DEPTH(NUM_POINTS)) u_ram_b (
    .clk, .we(wr_en), .waddr(count), .wdata({px, py}), .raddr(st.b), .rdata(rd_b)
  );

  // absolute difference and running sum
  always_comb begin
    va      = st.use_x ? rd_a[2*C-1:C] : rd_a[C-1:0];
    vb      = st.use_x ? rd_b[2*C-1:C] : rd_b[C-1:0];
    diff    = (va > vb) ? (va - vb) : (vb - va);
    acc_sum = acc + ACC_W'(diff);
  end

  // numerator 3n * 2^F and divisor k*S
  always_comb begin
    s_ext = DEN_W'(scale);
    n3    = DEN_W'(acc_sum) + (DEN_W'(acc_sum) << 1);
    num   = {n3, FRAC_BITS'(0)};
    unique case (st.k)
      K_ONE:   den = s_ext;
      K_TWO:   den = s_ext << 1;
      K_TEN:   den = (s_ext << 3) + (s_ext << 1);
      default: den = s_ext;
    endcase
  end

  assign div_start = (state == S_ACC) && st.grp_end && !st.is_scale && (scale != '0);

  fau_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk, .rst, .start(div_start), .num, .den, .done(div_done), .res(div_res)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      step      <= '0;
      feat      <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (end_of_set) begin
              count <= '0;
              if (set_full) begin
                state <= S_RD;
                step  <= '0;
                feat  <= '0;
                acc   <= '0;
              end else begin
                feature_index <= '0;
                feature_value <= '0;
                saturated     <= 1'b0;
                short_set     <= 1'b1;
                last_result   <= 1'b1;
              end
            end else if (wr_en) begin
              count <= count + 1'b1;
            end
          end
        end
        S_RD: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (!st.grp_end) begin
            acc   <= acc_sum;
            step  <= step + 1'b1;
            state <= S_RD;
          end else if (st.is_scale) begin
            scale <= S_W'(acc_sum);
            acc   <= '0;
            step  <= step + 1'b1;
            state <= S_RD;
          end else if (scale == '0) begin
            res_val <= '1;
            res_sat <= 1'b1;
            state   <= S_OUT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_val <= div_res.ovf ? '1 : div_res.quo;
            res_sat <= div_res.ovf;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            feature_index <= feat;
            feature_value <= res_val;
            saturated     <= res_sat;
            short_set     <= 1'b0;
            last_result   <= (feat == INDEX_W'(NUM_FEAT - 1));
            acc           <= '0;
            if (feat == INDEX_W'(NUM_FEAT - 1)) begin
              state <= S_IDLE;
            end else begin
              feat  <= feat + 1'b1;
              step  <= step + 1'b1;
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/fau_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fau_checker
// Port-level checks on the feature results.
// ---------------------------------------------------------------------------
module fau_checker import fau_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [INDEX_W-1:0]  feature_index,
  input wire logic [VALUE_W-1:0]  feature_value,
  input wire logic                saturated,
  input wire logic                short_set,
  input wire logic                last_result
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a short set gives one empty closing result
  a_short: assert property (@(posedge clk) disable iff (rst)
    out_valid && short_set |-> last_result && feature_index == '0 &&
                               feature_value == '0 && !saturated)
    else $error("malformed short-set result");

  // a full face closes on the last feature
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !short_set |-> (last_result == (feature_index == INDEX_W'(NUM_FEAT - 1))))
    else $error("last flag on wrong feature");

  // saturation always pins the value at full scale
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> feature_value == '1)
    else $error("saturated value not at maximum");

endmodule

bind facial_action_unit_features fau_checker u_fau_checker (.*);
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Checks the facial action unit feature block: landmark sets are sent as
// point requests, an in-bench predictor computes the expected features, and
// a monitor compares every feature result in order under random idling.
// ---------------------------------------------------------------------------
module tb;
  import fau_pkg::*;

  localparam int VMAX = 24'hFFFFFF;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [PT_W-1:0] x;
    logic [PT_W-1:0] y;
    logic            eos;
  } point_t;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] val;
    logic               sat;
    logic               short_s;
    logic               last;
  } feat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PT_W-1:0] point_x = '0;
  logic [PT_W-1:0] point_y = '0;
  logic end_of_set = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [INDEX_W-1:0] feature_index;
  logic [VALUE_W-1:0] feature_value;
  logic saturated, short_set, last_result;

  facial_action_unit_features u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .point_x(point_x), .point_y(point_y), .end_of_set(end_of_set),
    .out_valid(out_valid), .out_stall(out_stall),
    .feature_index(feature_index), .feature_value(feature_value),
    .saturated(saturated), .short_set(short_set), .last_result(last_result)
  );

  point_t pending_points[$];
  feat_t  expected_feats[$];
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_send = 1'b0;
  bit     in_taken = 1'b0;
  int     mismatches = 0;
  int     cycles = 0;
  int     faces_sent = 0;
  int     short_sent = 0;
  int     feats_seen = 0;

  // predictor state
  logic [PT_W-1:0] lm_x[NUM_POINTS];
  logic [PT_W-1:0] lm_y[NUM_POINTS];
  int pt_count = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint dy(int a, int b);
    return (lm_y[a] > lm_y[b]) ? lm_y[a] - lm_y[b] : lm_y[b] - lm_y[a];
  endfunction

  function automatic longint dx(int a, int b);
    return (lm_x[a] > lm_x[b]) ? lm_x[a] - lm_x[b] : lm_x[b] - lm_x[a];
  endfunction

  task automatic push_ratio(int idx, longint n, longint k, longint s);
    feat_t f;
    longint v;
    f.idx = idx[INDEX_W-1:0];
    f.short_s = 1'b0;
    f.last = (idx == NUM_FEAT - 1);
    f.sat = 1'b0;
    if (s == 0) begin
      v = VMAX;
      f.sat = 1'b1;
    end else begin
      v = ((n * 3) << 16) / (k * s);
      if (v > VMAX) begin
        v = VMAX;
        f.sat = 1'b1;
      end
    end
    f.val = v[VALUE_W-1:0];
    expected_feats = {expected_feats, f};
  endtask

  // Expected features for one accepted point request
  task automatic predict_point(point_t p);
    longint s, n;
    feat_t f;
    if (pt_count < NUM_POINTS) begin
      lm_x[pt_count] = p.x;
      lm_y[pt_count] = p.y;
      pt_count++;
    end
    if (!p.eos) return;
    if (pt_count < NUM_POINTS) begin
      pt_count = 0;
      f = '0;
      f.short_s = 1'b1;
      f.last = 1'b1;
      expected_feats = {expected_feats, f};
      return;
    end
    pt_count = 0;
    s = dx(0, 16) + dx(1, 15) + dx(2, 14);
    push_ratio(0, dy(21, 27) + dy(22, 27), 2, s);
    push_ratio(1, dy(17, 27) + dy(26, 27), 2, s);
    n = 0;
    for (int i = 17; i <= 26; i++) n += dy(i, 27);
    push_ratio(2, n, 10, s);
    push_ratio(3, dy(37, 27) + dy(44, 27), 2, s);
    push_ratio(4, dy(37, 41) + dy(38, 40) + dy(43, 47) + dy(44, 46), 2, s);
    push_ratio(5, dy(29, 27) + dy(30, 27), 1, s);
    push_ratio(6, dy(48, 33) + dy(54, 33), 2, s);
    push_ratio(7, dy(57, 33), 1, s);
    push_ratio(8, dx(48, 54), 1, s);
    n = 0;
    for (int i = 0; i < 5; i++) n += dy(49 + i, 59 - i);
    push_ratio(9, n, 1, s);
    push_ratio(10, dy(8, 27), 1, s);
  endtask

  // Driver: next request presented on the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      // move on only when the request was taken at the last rising edge
      if (!in_valid || in_taken) begin
        if (pending_points.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          point_t p;
          p = pending_points[0];
          pending_points.delete(0);
          point_x <= p.x;
          point_y <= p.y;
          end_of_set <= p.eos;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: predict on accepted requests, compare accepted results
  always @(posedge clk) begin
    in_taken = in_valid && !in_stall;
    cycles <= cycles + 1;
    if (!rst) begin
      if (in_valid && !in_stall)
        predict_point('{x: point_x, y: point_y, eos: end_of_set});
      if (out_valid && !out_stall) begin
        feat_t got, want;
        feats_seen <= feats_seen + 1;
        got = '{idx: feature_index, val: feature_value, sat: saturated,
                short_s: short_set, last: last_result};
        if (expected_feats.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected feature result %p", got);
        end else begin
          want = expected_feats[0];
          expected_feats.delete(0);
          if (got !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("feature mismatch: expected %p actual %p", want, got);
          end
        end
      end
    end
  end

  // Timeout watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Landmark set generator: random, extreme-value or clustered sets by kind
  task automatic queue_face(int kind);
    point_t p;
    int cx, w;
    cx = $urandom_range(300, 3800);
    w = $urandom_range(1, 250);
    for (int i = 0; i < NUM_POINTS; i++) begin
      case (kind)
        0: begin
          p.x = 12'($urandom);
          p.y = 12'($urandom);
        end
        1: begin
          p.x = 12'hFFF;
          p.y = (i % 2) ? 12'hFFF : 12'h000;
        end
        2: begin
          p.x = 12'd0;
          p.y = (i % 3) ? 12'h000 : 12'hFFF;
        end
        3: begin
          p.x = (i < 17) ? ((i < 8) ? 12'd0 : 12'hFFF) : 12'($urandom);
          p.y = 12'($urandom);
        end
        default: begin
          p.x = 12'(cx + $urandom_range(0, 2 * w) - w);
          p.y = 12'(cx + $urandom_range(0, 2 * w) - w);
        end
      endcase
      p.eos = (i == NUM_POINTS - 1);
      pending_points = {pending_points, p};
    end
    faces_sent++;
  endtask

  task automatic queue_short(int n);
    point_t p;
    for (int i = 0; i < n; i++) begin
      p.x = 12'($urandom);
      p.y = 12'($urandom);
      p.eos = (i == n - 1);
      pending_points = {pending_points, p};
    end
    short_sent++;
  endtask

  task automatic queue_long(int extra);
    queue_face(4);
    pending_points[$].eos = 1'b0;
    faces_sent--;
    for (int i = 0; i < extra; i++) begin
      point_t p;
      p.x = 12'($urandom);
      p.y = 12'($urandom);
      p.eos = (i == extra - 1);
      pending_points = {pending_points, p};
    end
    faces_sent++;
  endtask

  task automatic drain;
    while (pending_points.size() > 0 || in_valid || expected_feats.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 76 : ((ph == 3) ? 24 : 0);
      recv_stall_pct = (ph == 2) ? 76 : ((ph == 3) ? 24 : 0);
      if (ph == 0) begin
        // one-point short set, then a wide or random face
        queue_short(1);
        queue_face(($urandom_range(1) == 0) ? 3 : 0);
        // pause the sender after the short set until its result is back
        while (pending_points.size() > NUM_POINTS) @(posedge clk);
        hold_send = 1'b1;
        while (expected_feats.size() > 0 || in_valid) @(posedge clk);
        hold_send = 1'b0;
      end else if (ph == 1) begin
        // tight geometry (overflow likely) with points past the 68th
        queue_long(3);
      end else if (ph == 2) begin
        // zero scale: every feature saturates
        queue_face(($urandom_range(1) == 0) ? 1 : 2);
      end else begin
        queue_short($urandom_range(2, 67));
      end
      drain();
    end

    $display("covered %0d full faces and %0d short sets, %0d feature results",
             faces_sent, short_sent, feats_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
